>>> rtl/core/bph_pkg.sv
// ----------------------------------------------------------------------------
// bph_pkg: shared types and constants of the projection histogram
// Field widths, item mode codes and register indexes used by the channel
// interfaces and by the histogram core.
// ----------------------------------------------------------------------------
package bph_pkg;

  // Fixed widths of the item fields and of the configuration port.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned FILL_W    = 21;
  localparam int unsigned PEAK_W    = 11;
  localparam int unsigned REG_IDX_W = 1;

  // What an input item asks for.
  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL    = 2'd0,
    MODE_READ_COL = 2'd1,
    MODE_READ_ROW = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

endpackage

>>> rtl/core/bph_if.sv
// ----------------------------------------------------------------------------
// bph_in_if / bph_out_if: item channels of the projection histogram
// Valid/ready channels; an item moves at a rising edge with valid and ready
// both high.
// ----------------------------------------------------------------------------

// Input channel: one pixel or one bin read request per item.
interface bph_in_if;
  logic                        valid;
  logic                        ready;
  logic [bph_pkg::MODE_W-1:0]  mode;
  logic                        pixel_black;
  logic [bph_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, mode, pixel_black, read_index, input ready);
  modport sink   (input valid, mode, pixel_black, read_index, output ready);
endinterface

// Output channel: one result per input item.
interface bph_out_if;
  logic                        valid;
  logic                        ready;
  logic [bph_pkg::FILL_W-1:0]  fill_count;
  logic [bph_pkg::PEAK_W-1:0]  col_peak;
  logic [bph_pkg::IDX_W-1:0]   col_peak_index;
  logic [bph_pkg::PEAK_W-1:0]  row_peak;
  logic [bph_pkg::IDX_W-1:0]   row_peak_index;
  logic [bph_pkg::PEAK_W-1:0]  bin_value;
  logic                        frame_done;

  modport source (output valid, fill_count, col_peak, col_peak_index, row_peak,
                  row_peak_index, bin_value, frame_done, input ready);
  modport sink   (input valid, fill_count, col_peak, col_peak_index, row_peak,
                  row_peak_index, bin_value, frame_done, output ready);
endinterface

>>> rtl/core/bitmap_projection_histogram.sv
// ----------------------------------------------------------------------------
// bitmap_projection_histogram: column and row projection profile of a bitmap
// Counts black pixels per column and per row of a column-major frame, keeps
// the fill total and the first-reached peak of each profile, and serves reads
// of single column or row bins.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  in_ch     in         valid / ready      mode, pixel_black, read_index
//  out_ch    out        valid / ready      fill, peaks, peak indexes, bin, done
//  cfg       in         cfg_we_i           cfg_index_i, cfg_data_i
//
//  One item is accepted every cycle while out_ch takes the results; each
//  item passes the update stage register and then the result register.
//  The column and row count memories are read when an item is accepted and
//  written when it leaves the update stage, with forwarding between the two.
//  Reset and frame restarts take no clearing pass: an entry not yet written
//  in the current frame is recognized from the pixel position and reads as 0.
//  A stall on out_ch holds both stages; in_ch keeps accepting while a
//  stage is free.
// ----------------------------------------------------------------------------
module bitmap_projection_histogram #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bph_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [bph_pkg::SIZE_W-1:0]      cfg_data_i,
  bph_in_if.sink                          in_ch,
  bph_out_if.source                       out_ch
);

  // Address, size and count widths.
  localparam int unsigned COL_AW = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_AW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CCW    = HW;   // a column holds at most MAX_HEIGHT
  localparam int unsigned RCW    = WW;   // a row holds at most MAX_WIDTH
  localparam int unsigned FCW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam logic [WW-1:0] W_RESET = WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
  localparam logic [HW-1:0] H_RESET = HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

  // Item held between the memory read and the update.
  typedef struct packed {
    logic [bph_pkg::MODE_W-1:0] mode;
    logic                       black;
    logic                       ok;         // addressed entry is live this frame
    logic [COL_AW-1:0]          col;
    logic [ROW_AW-1:0]          row;
    logic                       new_frame;
    logic                       done;
  } s1_t;

  // Frame geometry and pixel position.
  logic [WW-1:0]     w_eff_q, w_eff_d;
  logic [HW-1:0]     h_eff_q, h_eff_d;
  logic [COL_AW-1:0] cur_col_q, cur_col_d;
  logic [ROW_AW-1:0] cur_row_q, cur_row_d;
  logic              frame_cmp_q, frame_cmp_d;
  logic              done_acc;

  // Pipeline control.
  logic in_acc, s1_adv, commit_pix;
  logic s1_valid_q, out_valid_q;
  s1_t  s1_q, s1_d;

  // Memories and their read registers.
  logic [CCW-1:0]    col_mem [MAX_WIDTH];
  logic [RCW-1:0]    row_mem [MAX_HEIGHT];
  logic [COL_AW-1:0] col_raddr;
  logic [ROW_AW-1:0] row_raddr;
  logic [CCW-1:0]    col_rd_q, col_fwd_val_q;
  logic [RCW-1:0]    row_rd_q, row_fwd_val_q;
  logic              col_fwd_q, row_fwd_q, col_fwd_d, row_fwd_d;

  // Accumulated statistics.
  logic [FCW-1:0]    fill_q, fill_base, fill_new;
  logic [CCW-1:0]    col_peak_q, col_peak_base, col_peak_new;
  logic [COL_AW-1:0] col_pos_q, col_pos_base, col_pos_new;
  logic [RCW-1:0]    row_peak_q, row_peak_base, row_peak_new;
  logic [ROW_AW-1:0] row_pos_q, row_pos_base, row_pos_new;
  logic [CCW-1:0]    col_run_q, col_new, col_data;
  logic [RCW-1:0]    row_new, row_data, row_old;

  // Result register.
  logic [bph_pkg::FILL_W-1:0] res_fill_q;
  logic [bph_pkg::PEAK_W-1:0] res_cpk_q, res_rpk_q, res_bin_q, res_bin_d;
  logic [bph_pkg::IDX_W-1:0]  res_cpos_q, res_rpos_q;
  logic                       res_done_q;

  // Handshakes.
  assign s1_adv      = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign commit_pix  = s1_valid_q && s1_adv && (s1_q.mode == bph_pkg::MODE_PIXEL);

  // Configured sizes, clamped into 1..MAX.
  always_comb begin
    w_eff_d = w_eff_q;
    h_eff_d = h_eff_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bph_pkg::REG_FRAME_WIDTH: begin
          if (cfg_data_i == '0) w_eff_d = WW'(1);
          else if (32'(cfg_data_i) > MAX_WIDTH) w_eff_d = WW'(MAX_WIDTH);
          else w_eff_d = WW'(cfg_data_i);
        end
        bph_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_data_i == '0) h_eff_d = HW'(1);
          else if (32'(cfg_data_i) > MAX_HEIGHT) h_eff_d = HW'(MAX_HEIGHT);
          else h_eff_d = HW'(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position: row inner, column outer.
  always_comb begin
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    frame_cmp_d = frame_cmp_q;
    done_acc    = 1'b0;
    if (cfg_we_i) begin
      cur_col_d   = '0;
      cur_row_d   = '0;
      frame_cmp_d = 1'b0;
    end else if (in_acc && (in_ch.mode == bph_pkg::MODE_PIXEL)) begin
      frame_cmp_d = 1'b0;
      if (32'(cur_row_q) == 32'(h_eff_q) - 32'd1) begin
        cur_row_d = '0;
        if (32'(cur_col_q) == 32'(w_eff_q) - 32'd1) begin
          cur_col_d   = '0;
          frame_cmp_d = 1'b1;
          done_acc    = 1'b1;
        end else begin
          cur_col_d = cur_col_q + 1'b1;
        end
      end else begin
        cur_row_d = cur_row_q + 1'b1;
      end
    end
  end

  // Accepted item: decide whether the addressed entry was written this frame.
  always_comb begin
    s1_d.mode      = in_ch.mode;
    s1_d.black     = in_ch.pixel_black;
    s1_d.col       = cur_col_q;
    s1_d.row       = cur_row_q;
    s1_d.new_frame = frame_cmp_q;
    s1_d.done      = done_acc;
    unique case (in_ch.mode)
      bph_pkg::MODE_PIXEL: begin
        // Every row is written once the first column is through.
        s1_d.ok = (cur_col_q != '0);
      end
      bph_pkg::MODE_READ_COL: begin
        s1_d.ok = (32'(in_ch.read_index) < 32'(w_eff_q)) &&
                  (frame_cmp_q || (32'(in_ch.read_index) < 32'(cur_col_q)) ||
                   ((32'(in_ch.read_index) == 32'(cur_col_q)) && (cur_row_q != '0)));
      end
      bph_pkg::MODE_READ_ROW: begin
        s1_d.ok = (32'(in_ch.read_index) < 32'(h_eff_q)) &&
                  (frame_cmp_q || (cur_col_q != '0) ||
                   (32'(in_ch.read_index) < 32'(cur_row_q)));
      end
      default: begin
        s1_d.ok = 1'b0;
      end
    endcase
  end

  // Read addresses, and forwarding from the write of the same edge.
  assign col_raddr = COL_AW'(in_ch.read_index);
  assign row_raddr = (in_ch.mode == bph_pkg::MODE_READ_ROW) ?
                     ROW_AW'(in_ch.read_index) : cur_row_q;
  assign col_fwd_d = commit_pix && (s1_q.col == col_raddr);
  assign row_fwd_d = commit_pix && (s1_q.row == row_raddr);

  // Column count memory.
  always_ff @(posedge clk_i) begin
    if (commit_pix) begin
      col_mem[s1_q.col] <= col_new;
    end
    if (in_acc) begin
      col_rd_q <= col_mem[col_raddr];
    end
  end

  // Row count memory.
  always_ff @(posedge clk_i) begin
    if (commit_pix) begin
      row_mem[s1_q.row] <= row_new;
    end
    if (in_acc) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  // Stage payload and forwarded values.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q          <= s1_d;
      col_fwd_q     <= col_fwd_d;
      row_fwd_q     <= row_fwd_d;
      col_fwd_val_q <= col_new;
      row_fwd_val_q <= row_new;
    end
  end

  assign col_data = col_fwd_q ? col_fwd_val_q : col_rd_q;
  assign row_data = row_fwd_q ? row_fwd_val_q : row_rd_q;

  // Count update for a pixel; a new frame starts from cleared totals.
  always_comb begin
    fill_base     = s1_q.new_frame ? '0 : fill_q;
    col_peak_base = s1_q.new_frame ? '0 : col_peak_q;
    col_pos_base  = s1_q.new_frame ? '0 : col_pos_q;
    row_peak_base = s1_q.new_frame ? '0 : row_peak_q;
    row_pos_base  = s1_q.new_frame ? '0 : row_pos_q;

    row_old  = s1_q.ok ? row_data : '0;
    row_new  = row_old + RCW'(s1_q.black);
    col_new  = (s1_q.row == '0) ? CCW'(s1_q.black) : col_run_q + CCW'(s1_q.black);
    fill_new = fill_base + FCW'(s1_q.black);

    col_peak_new = col_peak_base;
    col_pos_new  = col_pos_base;
    if (s1_q.black && (col_new > col_peak_base)) begin
      col_peak_new = col_new;
      col_pos_new  = s1_q.col;
    end
    row_peak_new = row_peak_base;
    row_pos_new  = row_pos_base;
    if (s1_q.black && (row_new > row_peak_base)) begin
      row_peak_new = row_new;
      row_pos_new  = s1_q.row;
    end
  end

  // Bin value for read items.
  always_comb begin
    unique case (s1_q.mode)
      bph_pkg::MODE_READ_COL: res_bin_d = s1_q.ok ? bph_pkg::PEAK_W'(col_data) : '0;
      bph_pkg::MODE_READ_ROW: res_bin_d = s1_q.ok ? bph_pkg::PEAK_W'(row_data) : '0;
      default:                res_bin_d = '0;
    endcase
  end

  // Control state, geometry and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q     <= W_RESET;
      h_eff_q     <= H_RESET;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      frame_cmp_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      col_peak_q  <= '0;
      col_pos_q   <= '0;
      row_peak_q  <= '0;
      row_pos_q   <= '0;
      col_run_q   <= '0;
    end else begin
      w_eff_q     <= w_eff_d;
      h_eff_q     <= h_eff_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      frame_cmp_q <= frame_cmp_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_we_i) begin
        fill_q     <= '0;
        col_peak_q <= '0;
        col_pos_q  <= '0;
        row_peak_q <= '0;
        row_pos_q  <= '0;
      end else if (commit_pix) begin
        fill_q     <= fill_new;
        col_peak_q <= col_peak_new;
        col_pos_q  <= col_pos_new;
        row_peak_q <= row_peak_new;
        row_pos_q  <= row_pos_new;
        col_run_q  <= col_new;
      end
    end
  end

  // Result register: pixels report the updated totals, reads the current ones.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      res_bin_q <= res_bin_d;
      if (s1_q.mode == bph_pkg::MODE_PIXEL) begin
        res_fill_q <= bph_pkg::FILL_W'(fill_new);
        res_cpk_q  <= bph_pkg::PEAK_W'(col_peak_new);
        res_cpos_q <= bph_pkg::IDX_W'(col_pos_new);
        res_rpk_q  <= bph_pkg::PEAK_W'(row_peak_new);
        res_rpos_q <= bph_pkg::IDX_W'(row_pos_new);
        res_done_q <= s1_q.done;
      end else begin
        res_fill_q <= bph_pkg::FILL_W'(fill_q);
        res_cpk_q  <= bph_pkg::PEAK_W'(col_peak_q);
        res_cpos_q <= bph_pkg::IDX_W'(col_pos_q);
        res_rpk_q  <= bph_pkg::PEAK_W'(row_peak_q);
        res_rpos_q <= bph_pkg::IDX_W'(row_pos_q);
        res_done_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.fill_count     = res_fill_q;
  assign out_ch.col_peak       = res_cpk_q;
  assign out_ch.col_peak_index = res_cpos_q;
  assign out_ch.row_peak       = res_rpk_q;
  assign out_ch.row_peak_index = res_rpos_q;
  assign out_ch.bin_value      = res_bin_q;
  assign out_ch.frame_done     = res_done_q;

  // The input side is open whenever the result register is free.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ch.ready)
    else $error("input not ready although the result register is free");

  // A finished frame leaves the position at the origin.
  a_done_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_cmp_q |-> ((cur_col_q == '0) && (cur_row_q == '0)))
    else $error("frame complete with position away from the origin");

  // The position stays inside the configured frame.
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_row_q) < 32'(h_eff_q)) && (32'(cur_col_q) < 32'(w_eff_q)))
    else $error("pixel position outside the frame");

  // No single column or row can hold more than the fill total.
  a_peak_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FCW'(col_peak_q) <= fill_q) && (FCW'(row_peak_q) <= fill_q))
    else $error("peak count exceeds fill total");

  // An item leaving the update stage lands in the result register.
  a_stage_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_q)
    else $error("item lost between update stage and result register");

endmodule
